/* sv/tdpt_pkg.sv */
package tdpt_pkg;

    // Default width of the candidate datapath.
    localparam int NUM_WIDTH_DEF = 32;

    // Width of the candidate field on the input stream.
    localparam int CAND_W = 32;

    // Width of the result stream data bus (one flag, padded to a byte).
    localparam int OUT_TDATA_W = 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture a new candidate
        logic init_d;     // set the trial divisor to three
        logic next_d;     // advance the trial divisor to the next odd number
        logic start_div;  // prepare the divider for a new remainder
        logic div_step;   // run one restoring division step
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_lt2;      // candidate is zero or one
        logic n_lt4;      // candidate is below four
        logic n_even;     // candidate is even
        logic div_last;   // the current division step is the final one
        logic d_gt_q;     // divisor exceeds the quotient, no divisor left
        logic rem_zero;   // remainder of the finished division is zero
    } sts_t;

endpackage

/* sv/tdpt_dpath.sv */
module tdpt_dpath
    import tdpt_pkg::*;
#(
    parameter int NUM_WIDTH = NUM_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic [CAND_W-1:0] candidate,
    input  cmd_t              cmd,
    output sts_t              sts
);

    localparam int CNT_W = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

    logic [NUM_WIDTH-1:0] n_reg,   n_next;
    logic [NUM_WIDTH-1:0] d_reg,   d_next;
    logic [NUM_WIDTH-1:0] rem_reg, rem_next;
    logic [NUM_WIDTH-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic [NUM_WIDTH:0]   rem_sh;
    logic [NUM_WIDTH:0]   diff;

    // One restoring step: bring down the next dividend bit and subtract the
    // divisor if it fits. Dividend bits leave the top of quo_reg while
    // quotient bits enter at the bottom.
    assign rem_sh = {rem_reg, quo_reg[NUM_WIDTH-1]};
    assign diff   = rem_sh - {1'b0, d_reg};

    always_comb
    begin
        n_next   = n_reg;
        d_next   = d_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            n_next = NUM_WIDTH'(candidate);
        end
        if (cmd.init_d)
        begin
            d_next = NUM_WIDTH'(3);
        end
        else if (cmd.next_d)
        begin
            d_next = d_reg + NUM_WIDTH'(2);
        end
        if (cmd.start_div)
        begin
            rem_next = '0;
            quo_next = n_reg;
            cnt_next = CNT_W'(NUM_WIDTH - 1);
        end
        else if (cmd.div_step)
        begin
            if (!diff[NUM_WIDTH])
            begin
                rem_next = diff[NUM_WIDTH-1:0];
                quo_next = {quo_reg[NUM_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[NUM_WIDTH-1:0];
                quo_next = {quo_reg[NUM_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    always_comb
    begin
        sts.n_lt2    = ((n_reg >> 1) == '0);
        sts.n_lt4    = ((n_reg >> 2) == '0);
        sts.n_even   = ~n_reg[0];
        sts.div_last = (cnt_reg == '0);
        sts.d_gt_q   = (d_reg > quo_reg);
        sts.rem_zero = (rem_reg == '0);
    end

endmodule

/* sv/tdpt_ctrl.sv */
module tdpt_ctrl
    import tdpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output logic prime_flag,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       res_reg,   res_next;
    logic       ov_reg,    ov_next;
    logic       of_reg,    of_next;
    logic       out_free;

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = ov_reg;
    assign prime_flag = of_reg;
    assign out_free   = !ov_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        ov_next    = ov_reg;
        of_next    = of_reg;
        cmd        = '0;

        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.n_lt2)
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else if (sts.n_lt4)
                begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (sts.n_even)
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.init_d    = 1'b1;
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (sts.d_gt_q)
                begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (sts.rem_zero)
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.next_d    = 1'b1;
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    of_next    = res_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        of_reg  <= of_next;
    end

    // A transaction on the input always starts the screening of small cases.
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_CHECK))
        else $error("accepted candidate did not enter the check state");

    // The divider keeps running until its final step.
    a_div_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && !sts.div_last) |=> (state_reg == ST_DIV))
        else $error("division left early");

    // A zero remainder from a divisor in range means a composite candidate.
    a_zero_rem_composite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && sts.rem_zero && !sts.d_gt_q)
        |=> (state_reg == ST_DONE && !res_reg))
        else $error("divisible candidate not reported as composite");

    // A waiting result is never overwritten by the next one.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && ov_reg && !m_tready)
        |=> (state_reg == ST_DONE && ov_reg && $stable(of_reg)))
        else $error("pending result overwritten");

endmodule

/* sv/trial_division_prime_test_top.sv */
// Trial-division primality tester.
// Input stream (s_tvalid/s_tready/s_tdata): one transaction carries one
// 32-bit unsigned candidate; only its low NUM_WIDTH bits are tested.
// Output stream (m_tvalid/m_tready/m_tdata): one transaction per candidate,
// bit 0 is the prime flag (1 = prime; 0 and 1 are reported as not prime).
//
// The block tests one candidate at a time. Zero, one, two, three and even
// values are settled in the check state, without division. Odd candidates
// go through a restoring bit-serial divider that yields quotient and
// remainder of the candidate by each odd trial divisor d = 3, 5, 7, ...;
// the search stops at the first zero remainder or once d exceeds the
// quotient. The next candidate is accepted only once the result has been
// handed to the output register.
//
// Reset clears the controller and the output valid flag. When the receiver
// stalls, the finished result waits in the output register; a following
// candidate is still accepted and processed, and its result is held back
// until the output register is free.
module trial_division_prime_test_top
    import tdpt_pkg::*;
#(
    parameter int NUM_WIDTH = NUM_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [CAND_W-1:0]      s_tdata,   // [31:0] candidate
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [0] prime_flag, [7:1] zero
);

    cmd_t cmd;
    sts_t sts;
    logic prime_flag;

    tdpt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .prime_flag (prime_flag),
        .cmd        (cmd),
        .sts        (sts)
    );

    tdpt_dpath #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .candidate (s_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The flag sits in the lowest bit, the rest of the byte is padding.
    assign m_tdata = {{(OUT_TDATA_W - 1){1'b0}}, prime_flag};

endmodule
